// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rld modules
// clocked on clk and disabled while rst_n is low; empty when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RLD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define RLD_ASSERT(lbl, prop, msg)
`define RLD_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- hw/rtl/rld_pkg.sv -----
// types and constants for the run list decoder
// no dependencies
`timescale 1ns / 1ps

package rld_pkg;

  localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;
  localparam int         LANES           = 8;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_END = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] cluster;
    logic [63:0] length;
    logic        sparse;
  } result_t;

endpackage

// ----- hw/rtl/rld_decode.sv -----
// byte-wise decode of the mapping pairs stream: phase, counters, accumulators
// depends on rld_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rld_decode import rld_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] byte_in,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase_r,       phase_nxt;
  logic [3:0]  length_size_r, length_size_nxt;
  logic [3:0]  offset_size_r, offset_size_nxt;
  logic [2:0]  byte_index_r,  byte_index_nxt;
  logic [63:0] length_acc_r,  length_acc_nxt;
  logic [63:0] delta_acc_r,   delta_acc_nxt;
  logic [63:0] cluster_acc_r, cluster_acc_nxt;

  logic [3:0]  count;
  logic [63:0] len_merged;
  logic [63:0] delta_merged;
  logic [63:0] delta_ext;
  logic [63:0] cluster_sum;
  logic [3:0]  lc;
  logic [3:0]  oc;

  assign count = {1'b0, byte_index_r} + 4'd1;
  assign lc    = byte_in[3:0];
  assign oc    = byte_in[7:4];

  // lane merge of the current byte, plus sign fill above the top offset byte
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      len_merged[i*8 +: 8]   = length_acc_r[i*8 +: 8];
      delta_merged[i*8 +: 8] = delta_acc_r[i*8 +: 8];
      if (byte_index_r == 3'(i)) begin
        len_merged[i*8 +: 8]   = length_acc_r[i*8 +: 8] | byte_in;
        delta_merged[i*8 +: 8] = delta_acc_r[i*8 +: 8] | byte_in;
      end
      if (4'(i) >= offset_size_r) begin
        delta_ext[i*8 +: 8] = {8{byte_in[7]}};
      end else begin
        delta_ext[i*8 +: 8] = delta_merged[i*8 +: 8];
      end
    end
  end

  assign cluster_sum = cluster_acc_r + delta_ext;

  always_comb begin
    phase_nxt       = phase_r;
    length_size_nxt = length_size_r;
    offset_size_nxt = offset_size_r;
    byte_index_nxt  = byte_index_r;
    length_acc_nxt  = length_acc_r;
    delta_acc_nxt   = delta_acc_r;
    cluster_acc_nxt = cluster_acc_r;
    res_valid       = 1'b0;
    res.status      = ST_RUN;
    res.cluster     = '0;
    res.length      = '0;
    res.sparse      = 1'b0;
    case (phase_r)
      PH_LENGTH: begin
        length_acc_nxt = len_merged;
        byte_index_nxt = byte_index_r + 3'd1;
        if (count >= length_size_r) begin
          byte_index_nxt = '0;
          if (offset_size_r == 4'd0) begin
            phase_nxt  = PH_HEADER;
            res_valid  = 1'b1;
            res.length = len_merged;
            res.sparse = 1'b1;
          end else begin
            phase_nxt = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        delta_acc_nxt  = delta_merged;
        byte_index_nxt = byte_index_r + 3'd1;
        if (count >= offset_size_r) begin
          cluster_acc_nxt = cluster_sum;
          phase_nxt       = PH_HEADER;
          byte_index_nxt  = '0;
          res_valid       = 1'b1;
          res.cluster     = cluster_sum;
          res.length      = length_acc_r;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
        if (byte_in == 8'd0) begin
          cluster_acc_nxt = '0;
          res_valid       = 1'b1;
          res.status      = ST_END;
        end else if (lc == 4'd0 || lc > MAX_FIELD_BYTES || oc > MAX_FIELD_BYTES) begin
          res_valid  = 1'b1;
          res.status = ST_BAD;
        end else begin
          length_size_nxt = lc;
          offset_size_nxt = oc;
          byte_index_nxt  = '0;
          length_acc_nxt  = '0;
          delta_acc_nxt   = '0;
          phase_nxt       = PH_LENGTH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      length_size_r <= '0;
      offset_size_r <= '0;
      byte_index_r  <= '0;
      length_acc_r  <= '0;
      delta_acc_r   <= '0;
      cluster_acc_r <= '0;
    end else if (take) begin
      phase_r       <= phase_nxt;
      length_size_r <= length_size_nxt;
      offset_size_r <= offset_size_nxt;
      byte_index_r  <= byte_index_nxt;
      length_acc_r  <= length_acc_nxt;
      delta_acc_r   <= delta_acc_nxt;
      cluster_acc_r <= cluster_acc_nxt;
    end
  end

  `RLD_ASSERT(a_offset_has_bytes, (phase_r == PH_OFFSET) |-> (offset_size_r != 4'd0), "offset phase with zero offset count")
  `RLD_ASSERT(a_len_index_in_range, (phase_r == PH_LENGTH) |-> ({1'b0, byte_index_r} < length_size_r), "length byte index past length count")
  `RLD_ASSERT_NEXT(a_end_clears_cluster, take && res_valid && res.status == ST_END, cluster_acc_r == 64'd0, "end of list did not clear cluster")

endmodule

// ----- hw/rtl/rld_outbuf.sv -----
// two-entry result buffer: output register plus skid register
// depends on rld_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rld_outbuf import rld_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_take,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_valid_r,  out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r,   out_data_nxt;
  result_t skid_data_r,  skid_data_nxt;
  logic    pop;

  assign pop       = out_valid_r && !out_stall;
  assign can_take  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_data_nxt  = push_data;
        out_valid_nxt = push;
      end
    end else if (push) begin
      // output held, park the new result
      skid_data_nxt  = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `RLD_ASSERT(a_skid_needs_out, skid_valid_r |-> out_valid_r, "skid entry without output entry")
  `RLD_ASSERT(a_no_push_when_full, push |-> !skid_valid_r, "result pushed into full buffer")
  `RLD_ASSERT_NEXT(a_skid_moves_up, skid_valid_r && !out_stall, out_valid_r && out_data_r == $past(skid_data_r), "skid entry not moved to output")

endmodule

// ----- hw/rtl/ntfs_runlist_decoder.sv -----
// channel  | ports                                                       | dir
// input    | in_valid, in_stall, in_byte                                 | in
// result   | out_valid, out_stall, out_status, out_run_cluster,
//          | out_run_length, out_run_sparse                              | out
// one stream byte is taken per cycle while in_stall is low; a result is registered
// into the output buffer by the header, last length byte or last offset byte that completes it.
// the decode state is updated in the cycle the byte is taken, and the 64-bit
// cluster add sits between the state registers and the output register.
// a two-entry output buffer keeps input flowing while one result is stalled.
// reset (rst_n low, synchronous) returns to awaiting a header with cluster 0.
// depends on rld_pkg, rld_decode, rld_outbuf
`timescale 1ns / 1ps

module ntfs_runlist_decoder import rld_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [63:0] out_run_cluster,
  output logic [63:0]        out_run_length,
  output logic               out_run_sparse
);

  logic    take;
  logic    can_take;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign in_stall = !can_take;
  assign take     = in_valid && can_take;

  rld_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .byte_in   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  rld_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && res_valid),
    .push_data (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_status      = out_data.status;
  assign out_run_cluster = $signed(out_data.cluster);
  assign out_run_length  = out_data.length;
  assign out_run_sparse  = out_data.sparse;

endmodule
